>>> design/mspc_pkg.sv
`default_nettype none

package mspc_pkg;

    // field widths
    localparam int TICKS_W   = 4;
    localparam int SAMPLE_W  = 10;
    localparam int SPEED_W   = 8;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // stream widths, packed fields rounded up to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // default parameter values
    localparam int ADC_BITS_DEFAULT  = 10;
    localparam int SPEED_MAX_DEFAULT = 255;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_THRESH = 3'd4;

    // register reset values
    localparam logic [HOLD_W-1:0]   HOLD_TIME_RESET   = 16'd400;
    localparam logic [SPEED_W-1:0]  MIN_SPEED_RESET   = 8'd50;
    localparam logic [SAMPLE_W-1:0] UP_THRESH_RESET   = 10'd441;
    localparam logic [SAMPLE_W-1:0] DOWN_THRESH_RESET = 10'd603;
    localparam logic [SAMPLE_W-1:0] TOP_THRESH_RESET  = 10'd766;

    // speed presets
    localparam logic [SPEED_W-1:0] SPEED_STOPPED = 8'd100;
    localparam logic [SPEED_W-1:0] SPEED_OFF     = 8'd150;

    // saturation point of the hold counter
    localparam logic [HOLD_W-1:0] HOLD_SAT = 16'hFFFF;

    // power button tracking mode
    typedef enum logic [1:0] {
        MODE_UP     = 2'd0,
        MODE_DOWN   = 2'd1,
        MODE_IGNORE = 2'd2
    } button_mode_t;

endpackage

`default_nettype wire

>>> design/motor_speed_panel_controller.sv
// Motor speed panel controller
//
// Each input item on the s_ channel is one control pass: elapsed ms ticks,
// the power button level, the debounced start button level and a ladder
// ADC sample. Each item yields exactly one result item on the m_ channel:
// drive duty, power LED, running flag and the stored speed after the pass.
// Configuration (hold time, speed floor, ladder thresholds) is written by the user
// through cfg_wr_en/cfg_addr/cfg_wdata, only while idle (not enforced by the block).
//
// The pass is evaluated in one level of compare and increment logic from
// the accepted item and the control state, and lands in the result register
// at the accepting edge. Throughput is one item per cycle, set by that single
// state update, while the receiver is not stalling the result register.
//
// s_tready is high whenever the result register is empty or being taken,
// so a stalled receiver holds the pending result and blocks only the next
// item. Reset (aresetn low, synchronous) empties the result register,
// restores all configuration defaults and brings the panel up powered,
// stopped, with speed 100.

`default_nettype none

module motor_speed_panel_controller
    import mspc_pkg::*;
#(
    parameter int ADC_BITS  = ADC_BITS_DEFAULT,
    parameter int SPEED_MAX = SPEED_MAX_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // elapsed_ticks[3:0], power_pressed[4], start_level[5], ladder_sample[15:6]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // drive_duty[7:0], power_led[8], motor_running[9], set_speed[17:10], zero[23:18]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [SPEED_W:0] SPEED_CAP =
        (SPEED_MAX > 255) ? 9'd255 : 9'(SPEED_MAX);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

    // configuration registers
    logic [HOLD_W-1:0]   hold_time_reg;
    logic [SPEED_W-1:0]  min_speed_reg;
    logic [SAMPLE_W-1:0] up_thresh_reg;
    logic [SAMPLE_W-1:0] down_thresh_reg;
    logic [SAMPLE_W-1:0] top_thresh_reg;

    // control state
    logic                powered_reg, powered_next;
    button_mode_t        mode_reg, mode_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                last_pwr_reg;
    logic                run_reg, run_next;
    logic                last_start_reg, last_start_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [SPEED_W-1:0]  duty_reg, duty_next;

    // result register
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // unpacked input fields
    logic [TICKS_W-1:0]  in_ticks;
    logic                in_pwr;
    logic                in_start;
    logic [SAMPLE_W-1:0] in_sample;

    logic                accept;
    logic                pwr_rise;
    logic                pwr_fall;
    button_mode_t        mode_edge;
    logic [HOLD_W:0]     hold_sum;
    logic [HOLD_W-1:0]   hold_edge;
    logic                run_toggled;
    logic [SPEED_W:0]    speed_up;
    logic [SPEED_W:0]    speed_floor;
    logic [SPEED_W:0]    speed_dn;
    logic [SPEED_W-1:0]  speed_stepped;

    assign in_ticks  = s_tdata[3:0];
    assign in_pwr    = s_tdata[4];
    assign in_start  = s_tdata[5];
    assign in_sample = s_tdata[15:6] & SAMPLE_MASK;

    // handshake: next item may enter while the result is being taken
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg   <= HOLD_TIME_RESET;
            min_speed_reg   <= MIN_SPEED_RESET;
            up_thresh_reg   <= UP_THRESH_RESET;
            down_thresh_reg <= DOWN_THRESH_RESET;
            top_thresh_reg  <= TOP_THRESH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HOLD_TIME:   hold_time_reg   <= cfg_wdata;
                REG_MIN_SPEED:   min_speed_reg   <= cfg_wdata[SPEED_W-1:0];
                REG_UP_THRESH:   up_thresh_reg   <= cfg_wdata[SAMPLE_W-1:0];
                REG_DOWN_THRESH: down_thresh_reg <= cfg_wdata[SAMPLE_W-1:0];
                REG_TOP_THRESH:  top_thresh_reg  <= cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // power button edges and hold counter
    always_comb begin
        pwr_rise = in_pwr && !last_pwr_reg;
        pwr_fall = !in_pwr && last_pwr_reg;
        if (pwr_rise) begin
            mode_edge = MODE_DOWN;
        end else if (pwr_fall) begin
            mode_edge = MODE_UP;
        end else begin
            mode_edge = mode_reg;
        end
        hold_sum = {1'b0, hold_reg} + {{(HOLD_W + 1 - TICKS_W){1'b0}}, in_ticks};
        if (pwr_rise) begin
            hold_edge = '0;
        end else if (hold_sum[HOLD_W]) begin
            hold_edge = HOLD_SAT;
        end else begin
            hold_edge = hold_sum[HOLD_W-1:0];
        end
    end

    // speed step from the ladder sample, chained threshold tests
    always_comb begin
        speed_up = {1'b0, speed_reg} + 9'd1;
        if (speed_up >= SPEED_CAP) begin
            speed_up = SPEED_CAP;
        end
        speed_floor = {1'b0, min_speed_reg} + 9'd1;
        if ({1'b0, speed_reg} <= speed_floor) begin
            speed_dn = speed_floor;
        end else begin
            speed_dn = {1'b0, speed_reg} - 9'd1;
        end
        if (speed_dn > SPEED_CAP) begin
            speed_dn = SPEED_CAP;
        end
        priority if (in_sample < up_thresh_reg) begin
            speed_stepped = speed_reg;
        end else if (in_sample < down_thresh_reg) begin
            speed_stepped = speed_up[SPEED_W-1:0];
        end else if (in_sample < top_thresh_reg) begin
            speed_stepped = speed_dn[SPEED_W-1:0];
        end else begin
            speed_stepped = speed_reg;
        end
    end

    // control pass
    always_comb begin
        powered_next    = powered_reg;
        mode_next       = mode_edge;
        hold_next       = hold_edge;
        run_next        = run_reg;
        last_start_next = last_start_reg;
        speed_next      = speed_reg;
        duty_next       = duty_reg;
        run_toggled     = run_reg ^ (last_start_reg && !in_start);
        if (mode_edge == MODE_DOWN) begin
            // button held: only the hold time matters
            if (hold_edge > hold_time_reg) begin
                powered_next = !powered_reg;
                mode_next    = MODE_IGNORE;
            end
        end else if (powered_reg) begin
            run_next        = run_toggled;
            last_start_next = in_start;
            if (run_toggled) begin
                duty_next  = speed_reg;
                speed_next = speed_stepped;
            end else begin
                duty_next  = 8'd0;
                speed_next = SPEED_STOPPED;
            end
        end else begin
            duty_next  = 8'd0;
            speed_next = SPEED_OFF;
            run_next   = 1'b0;
        end
    end

    // state update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            powered_reg    <= 1'b1;
            mode_reg       <= MODE_UP;
            hold_reg       <= '0;
            last_pwr_reg   <= 1'b0;
            run_reg        <= 1'b0;
            last_start_reg <= 1'b1;
            speed_reg      <= SPEED_STOPPED;
            duty_reg       <= 8'd0;
        end else if (accept) begin
            powered_reg    <= powered_next;
            mode_reg       <= mode_next;
            hold_reg       <= hold_next;
            last_pwr_reg   <= in_pwr;
            run_reg        <= run_next;
            last_start_reg <= last_start_next;
            speed_reg      <= speed_next;
            duty_reg       <= duty_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {6'd0, speed_next, run_next, powered_next, duty_next};
        end
    end

endmodule

`default_nettype wire

>>> design/mspc_checker.sv
`default_nettype none

module mspc_checker
    import mspc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    // a pending result is held until taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    // every accepted item shows a result in the next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // an empty result register never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // motor not running means no drive
    a_idle_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero duty while motor not running");

endmodule

bind motor_speed_panel_controller mspc_checker u_mspc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
